[hw/rtl/lsf_pkg.sv]
// Shared constants, widths and codes of the learning switch forwarder.
// No dependencies; imported by the forwarder top level and its port checker.
`timescale 1ns / 1ps

package lsf_pkg;

	localparam int NUM_PORTS  = 8;
	localparam int SEEN_DEPTH = 128;

	localparam int MAC_W      = 48;
	localparam int SEQ_W      = 32;
	localparam int PORT_W     = 3;
	localparam int ACT_W      = 3;
	localparam int FLOOD_W    = 8;
	localparam int AP_W       = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = MAC_W;

	localparam int IN_USED_W   = PORT_W + 2 * MAC_W + SEQ_W;
	localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
	localparam int OUT_USED_W  = PORT_W + FLOOD_W + 1;
	localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

	// seen-table entry: {sequence, destination, source}
	localparam int ENTRY_W = 2 * MAC_W + SEQ_W;
	localparam int SEEN_AW = $clog2(SEEN_DEPTH);
	localparam int SEEN_CW = $clog2(SEEN_DEPTH + 1);

	localparam int PIDX_W = $clog2(NUM_PORTS);
	localparam int PCNT_W = $clog2(NUM_PORTS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PORTS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONNECTED_MASK = 2'd2;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_DROP    = 3'd0,
		ACT_LOCAL   = 3'd1,
		ACT_UNICAST = 3'd2,
		ACT_FLOOD   = 3'd3,
		ACT_CLEARED = 3'd4
	} action_t;

endpackage

[hw/rtl/lsf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/learning_switch_forwarder_unit.sv]
// Learning switch forwarder: per-header forwarding decision with a seen-frame table.
// Depends on lsf_pkg and lsf_ram.
`timescale 1ns / 1ps

// Usage:
//   Slave stream: s_tuser is the operation (frame header or clear seen table), s_tdata
//   the header. Master stream: m_tuser is the action, m_tdata egress port, flood mask
//   and learned flag. One result per accepted item, in order.
//   Configuration: cfg_we/cfg_index/cfg_wdata write own MAC, active port count and
//   connected mask; write only while no item is in flight.
//   Timing: s_tready is high only while the sequencer is idle. A clear goes straight
//   from idle to the finish state. For a frame header the seen table is scanned one
//   entry a cycle through the RAM read port (up to 128), then the active port slots
//   are scanned once for the source and, unless the destination is the own MAC, once
//   for the destination through one shared 48-bit comparator.
//   The result sits in an output register: a new item is accepted while it waits,
//   and the sequencer holds its next result until m_tready takes the pending one.
//   Reset: port slots and seen count cleared, registers to own MAC 0, eight active
//   ports, all connected. The seen RAM itself is not cleared; the count bounds reads.

module learning_switch_forwarder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// ingress_port, source_mac, dst_mac, frame_sequence
	input  logic [lsf_pkg::IN_DATA_W-1:0]     s_tdata,
	// operation
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// egress_port, flood_mask, learned
	output logic [lsf_pkg::OUT_DATA_W-1:0]    m_tdata,
	// action
	output logic [lsf_pkg::ACT_W-1:0]         m_tuser,
	input  logic                              cfg_we,
	input  logic [lsf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	import lsf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEEN,
		ST_SRC,
		ST_LEARN,
		ST_DST,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [MAC_W-1:0]   own_mac_q;
	logic [AP_W-1:0]    active_ports_q;
	logic [FLOOD_W-1:0] connected_mask_q;

	logic [MAC_W-1:0]   slots_q [NUM_PORTS];
	logic [SEEN_CW-1:0] seen_count_q;

	logic [PORT_W-1:0]  ingress_q;
	logic [MAC_W-1:0]   src_q;
	logic [MAC_W-1:0]   dst_q;
	logic [SEQ_W-1:0]   seq_q;

	logic [SEEN_CW-1:0] issue_q;
	logic               cmp_v_s1;
	logic [PCNT_W-1:0]  slot_idx_q;
	logic               src_found_q;

	action_t            act_q;
	logic [PORT_W-1:0]  egress_q;
	logic [FLOOD_W-1:0] flood_q;
	logic               learned_q;

	logic               out_valid_q;
	action_t            out_act_q;
	logic [PORT_W-1:0]  out_egress_q;
	logic [FLOOD_W-1:0] out_flood_q;
	logic               out_learned_q;

	logic [PCNT_W-1:0]  n_act;
	logic               rd_en;
	logic [ENTRY_W-1:0] rd_data;
	logic               seen_hit;
	logic [MAC_W-1:0]   slot_key;
	logic               slot_hit;
	logic               slot_more;
	logic               ingress_ok;
	logic               seen_room;
	logic [FLOOD_W-1:0] flood_mask;
	logic               out_load;

	always_comb begin
		if (32'(active_ports_q) > NUM_PORTS) begin
			n_act = PCNT_W'(NUM_PORTS);
		end else begin
			n_act = PCNT_W'(active_ports_q);
		end
	end

	assign rd_en      = (state_q == ST_SEEN) && (issue_q < seen_count_q);
	assign seen_hit   = cmp_v_s1 && (rd_data == {seq_q, dst_q, src_q});
	assign slot_key   = (state_q == ST_DST) ? dst_q : src_q;
	assign slot_more  = slot_idx_q < n_act;
	assign slot_hit   = slots_q[slot_idx_q[PIDX_W-1:0]] == slot_key;
	assign ingress_ok = 32'(ingress_q) < 32'(n_act);
	assign seen_room  = seen_count_q < SEEN_CW'(SEEN_DEPTH);
	assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || m_tready);

	always_comb begin
		flood_mask = '0;
		for (int p = 0; p < FLOOD_W; p++) begin
			flood_mask[p] = (p < 32'(n_act)) && (p != 32'(ingress_q)) && connected_mask_q[p];
		end
	end

	lsf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SEEN_DEPTH)
	) u_seen_ram (
		.clk   (clk),
		.we    ((state_q == ST_DST) && !slot_more && seen_room),
		.waddr (seen_count_q[SEEN_AW-1:0]),
		.wdata ({seq_q, dst_q, src_q}),
		.re    (rd_en),
		.raddr (issue_q[SEEN_AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q        <= '0;
			active_ports_q   <= AP_W'(8);
			connected_mask_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_MAC:        own_mac_q        <= cfg_wdata;
				REG_ACTIVE_PORTS:   active_ports_q   <= cfg_wdata[AP_W-1:0];
				REG_CONNECTED_MASK: connected_mask_q <= cfg_wdata[FLOOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seen_count_q <= '0;
			cmp_v_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				slots_q[i] <= '0;
			end
		end else begin
			cmp_v_s1 <= rd_en;
			// output register: load a finished decision, or drop the one just taken
			if (out_load) begin
				out_valid_q   <= 1'b1;
				out_act_q     <= act_q;
				out_egress_q  <= egress_q;
				out_flood_q   <= flood_q;
				out_learned_q <= learned_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ingress_q   <= s_tdata[2:0];
						src_q       <= s_tdata[50:3];
						dst_q       <= s_tdata[98:51];
						seq_q       <= s_tdata[130:99];
						issue_q     <= '0;
						slot_idx_q  <= '0;
						src_found_q <= 1'b0;
						egress_q    <= '0;
						flood_q     <= '0;
						learned_q   <= 1'b0;
						if (s_tuser == OP_CLEAR) begin
							seen_count_q <= '0;
							act_q        <= ACT_CLEARED;
							state_q      <= ST_FINISH;
						end else begin
							state_q <= ST_SEEN;
						end
					end
				end

				// one read issued and one entry compared per cycle
				ST_SEEN: begin
					if (seen_hit) begin
						act_q   <= ACT_DROP;
						state_q <= ST_FINISH;
					end else if (!rd_en && !cmp_v_s1) begin
						state_q <= ST_SRC;
					end else if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
				end

				ST_SRC: begin
					if (slot_more && slot_hit) begin
						src_found_q <= 1'b1;
						state_q     <= ST_LEARN;
					end else if (slot_more) begin
						slot_idx_q <= slot_idx_q + 1'b1;
					end else begin
						state_q <= ST_LEARN;
					end
				end

				ST_LEARN: begin
					slot_idx_q <= '0;
					if (!src_found_q && ingress_ok) begin
						slots_q[PIDX_W'(ingress_q)] <= src_q;
						learned_q                   <= 1'b1;
					end
					if (dst_q == own_mac_q) begin
						act_q   <= ACT_LOCAL;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DST;
					end
				end

				ST_DST: begin
					if (slot_more && slot_hit) begin
						act_q    <= ACT_UNICAST;
						egress_q <= PORT_W'(slot_idx_q);
						state_q  <= ST_FINISH;
					end else if (slot_more) begin
						slot_idx_q <= slot_idx_q + 1'b1;
					end else begin
						// flood; the RAM write of the entry happens this cycle if the table has room
						act_q   <= ACT_FLOOD;
						flood_q <= flood_mask;
						if (seen_room) begin
							seen_count_q <= seen_count_q + 1'b1;
						end
						state_q <= ST_FINISH;
					end
				end

				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_act_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
		out_learned_q, out_flood_q, out_egress_q};

endmodule

[hw/rtl/lsf_checker.sv]
// Port-level checks for the learning switch forwarder, bound to its top level.
// Depends on lsf_pkg and learning_switch_forwarder_unit.
`timescale 1ns / 1ps

module lsf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lsf_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [lsf_pkg::ACT_W-1:0]      m_tuser
);

	import lsf_pkg::*;

	// the sequencer is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("s_tready high right after an input transfer");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_egress_only_unicast: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ACT_UNICAST) |-> (m_tdata[2:0] == '0))
		else $error("egress port set on a non-unicast result");

	a_flood_only_flood: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ACT_FLOOD) |-> (m_tdata[10:3] == '0))
		else $error("flood mask set on a non-flood result");

	a_no_learn_on_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == ACT_DROP) || (m_tuser == ACT_CLEARED)) |-> !m_tdata[11])
		else $error("learned flag set on a drop or clear");

endmodule

bind learning_switch_forwarder_unit lsf_checker u_lsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
